// ----- hdl/stfp_pkg.sv -----
// stfp_pkg: shared types, constants and helpers for the serial tagged field parser
// no dependencies; used by stfp_ctrl, stfp_dp and serial_tagged_field_parser
package stfp_pkg;

    // bytes in one latched text slot; the collect buffer holds one less
    localparam int TEXT_BYTES = 8;
    localparam int BUF_BYTES  = TEXT_BYTES - 1;
    localparam int CNT_W      = $clog2(TEXT_BYTES);

    localparam int TEXT_W = 64;
    localparam int VAL_W  = 25;
    localparam int SHOW_W = 21;
    localparam int ACC_W  = VAL_W - 1;
    localparam int EV_W   = 3;

    localparam logic [7:0] CH_VEL   = 8'h56;  // 'V'
    localparam logic [7:0] CH_RPM   = 8'h53;  // 'S'
    localparam logic [7:0] CH_GEAR  = 8'h45;  // 'E'
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic signed [VAL_W-1:0] SHOW_LIMIT = VAL_W'(100);

    typedef enum logic [EV_W-1:0] {
        EV_STORED   = 3'd0,
        EV_VEL      = 3'd1,
        EV_RPM      = 3'd2,
        EV_GEAR     = 3'd3,
        EV_OVERFLOW = 3'd4
    } t_event;

    // controller to datapath
    typedef struct packed {
        logic accept;   // capture the incoming byte, arm the conversion
        logic step;     // one conversion step
        logic commit;   // update state and result registers
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_vel;     // captured byte is the velocity terminator
        logic conv_done;  // conversion finished
    } t_status;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- hdl/stfp_ctrl.sv -----
// stfp_ctrl: sequencing state machine of the serial tagged field parser
// depends on stfp_pkg for the command and status structs
module stfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  stfp_pkg::t_status i_status,
    output stfp_pkg::t_cmd    o_cmd
);
    import stfp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_HOLD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!i_status.is_vel || i_status.conv_done) begin
                    n_state = ST_HOLD;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hdl/stfp_dp.sv -----
// stfp_dp: collect buffer, text slots and byte-serial decimal conversion
// depends on stfp_pkg for constants, structs and character helpers
module stfp_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [7:0]                             i_rx_byte,
    input  stfp_pkg::t_cmd                         i_cmd,
    output stfp_pkg::t_status                      o_status,
    output logic [stfp_pkg::EV_W-1:0]              o_event_res,
    output logic [stfp_pkg::TEXT_W-1:0]            o_velocity_text,
    output logic [stfp_pkg::TEXT_W-1:0]            o_rpm_text,
    output logic [stfp_pkg::TEXT_W-1:0]            o_gear_text,
    output logic signed [stfp_pkg::VAL_W-1:0]      o_velocity_value,
    output logic signed [stfp_pkg::SHOW_W-1:0]     o_velocity_shown
);
    import stfp_pkg::*;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_SIGN,
        PH_DIGIT
    } t_phase;

    logic [7:0]               r_byte;
    logic [7:0]               r_buf [BUF_BYTES];
    logic [7:0]               n_buf [BUF_BYTES];
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic [TEXT_W-1:0]        r_vel_slot, n_vel_slot;
    logic [TEXT_W-1:0]        r_rpm_slot, n_rpm_slot;
    logic [TEXT_W-1:0]        r_gear_slot, n_gear_slot;
    logic signed [VAL_W-1:0]  r_vel_num, n_vel_num;
    t_event                   r_ev, n_ev;

    t_phase                   r_phase, n_phase;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic                     r_neg, n_neg;
    logic                     r_done, n_done;
    logic [ACC_W-1:0]         r_acc, n_acc;

    logic [7:0]               cur;
    logic                     in_range;
    logic [TEXT_W-1:0]        packed_text;
    logic signed [VAL_W-1:0]  conv_val;

    // byte under the conversion pointer
    always_comb begin
        cur = '0;
        for (int k = 0; k < BUF_BYTES; k++) begin
            if (r_idx == CNT_W'(k)) begin
                cur = r_buf[k];
            end
        end
    end

    assign in_range = (r_idx < CNT_W'(BUF_BYTES));

    always_comb begin
        packed_text = '0;
        for (int k = 0; k < BUF_BYTES; k++) begin
            packed_text[8*k +: 8] = r_buf[k];
        end
    end

    assign conv_val = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});

    // conversion sequencer: blanks, then optional sign, then digits
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_done  = r_done;
        n_acc   = r_acc;
        if (i_cmd.accept) begin
            n_phase = PH_BLANK;
            n_idx   = '0;
            n_neg   = 1'b0;
            n_done  = 1'b0;
            n_acc   = '0;
        end else if (i_cmd.step) begin
            case (r_phase)
                PH_BLANK: begin
                    if (!in_range) begin
                        n_done = 1'b1;
                    end else if (is_blank(cur)) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_phase = PH_SIGN;
                    end
                end
                PH_SIGN: begin
                    if (in_range && (cur == CH_PLUS || cur == CH_MINUS)) begin
                        n_neg = (cur == CH_MINUS);
                        n_idx = r_idx + 1'b1;
                    end
                    n_phase = PH_DIGIT;
                end
                PH_DIGIT: begin
                    if (in_range && is_digit(cur)) begin
                        // acc * 10 as two shifts and an add
                        n_acc = (r_acc << 3) + (r_acc << 1)
                              + ACC_W'(cur - CH_ZERO);
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_done = 1'b1;
                    end
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end
    end

    // state update at the end of each request
    always_comb begin
        n_buf       = r_buf;
        n_fill      = r_fill;
        n_vel_slot  = r_vel_slot;
        n_rpm_slot  = r_rpm_slot;
        n_gear_slot = r_gear_slot;
        n_vel_num   = r_vel_num;
        n_ev        = r_ev;
        if (i_cmd.commit) begin
            if (r_byte == CH_VEL || r_byte == CH_RPM || r_byte == CH_GEAR) begin
                if (r_byte == CH_VEL) begin
                    n_vel_num  = conv_val;
                    n_vel_slot = packed_text;
                    n_ev       = EV_VEL;
                end else if (r_byte == CH_RPM) begin
                    n_rpm_slot = packed_text;
                    n_ev       = EV_RPM;
                end else begin
                    n_gear_slot = packed_text;
                    n_ev        = EV_GEAR;
                end
                for (int k = 0; k < BUF_BYTES; k++) begin
                    n_buf[k] = '0;
                end
                n_fill = '0;
            end else if (r_fill < CNT_W'(BUF_BYTES)) begin
                for (int k = 0; k < BUF_BYTES; k++) begin
                    if (r_fill == CNT_W'(k)) begin
                        n_buf[k] = r_byte;
                    end
                end
                n_fill = r_fill + 1'b1;
                n_ev   = EV_STORED;
            end else begin
                // buffer full: drop the byte and start over
                for (int k = 0; k < BUF_BYTES; k++) begin
                    n_buf[k] = '0;
                end
                n_fill = '0;
                n_ev   = EV_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_rx_byte;
        end
        r_acc <= n_acc;
        r_idx <= n_idx;
        r_neg <= n_neg;
        r_ev  <= n_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BUF_BYTES; k++) begin
                r_buf[k] <= '0;
            end
            r_fill      <= '0;
            r_vel_slot  <= '0;
            r_rpm_slot  <= '0;
            r_gear_slot <= '0;
            r_vel_num   <= '0;
            r_phase     <= PH_BLANK;
            r_done      <= 1'b0;
        end else begin
            r_buf       <= n_buf;
            r_fill      <= n_fill;
            r_vel_slot  <= n_vel_slot;
            r_rpm_slot  <= n_rpm_slot;
            r_gear_slot <= n_gear_slot;
            r_vel_num   <= n_vel_num;
            r_phase     <= n_phase;
            r_done      <= n_done;
        end
    end

    assign o_status.is_vel    = (r_byte == CH_VEL);
    assign o_status.conv_done = r_done;

    assign o_event_res      = EV_W'(r_ev);
    assign o_velocity_text  = r_vel_slot;
    assign o_rpm_text       = r_rpm_slot;
    assign o_gear_text      = r_gear_slot;
    assign o_velocity_value = r_vel_num;
    assign o_velocity_shown = (r_vel_num > SHOW_LIMIT) ? SHOW_LIMIT[SHOW_W-1:0]
                                                       : r_vel_num[SHOW_W-1:0];

endmodule

// ----- hdl/serial_tagged_field_parser.sv -----
// serial_tagged_field_parser: top level, joins controller and datapath
// depends on stfp_pkg, stfp_ctrl and stfp_dp
// sequence: each accepted byte passes through the convert and hold states, and o_valid rises
// with the commit from the hold state; for 'V' the convert state runs the byte-serial
// decimal conversion that walks the collect buffer, so 'V' takes longer
// requests: o_ready is high only in the idle state, so no byte is taken while one is in flight;
// a result left waiting for i_ready holds the next request in the hold state
// reset: synchronous active-low i_rst_n clears buffer, fill count, slots and number
module serial_tagged_field_parser (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [7:0]                             i_rx_byte,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [stfp_pkg::EV_W-1:0]              o_event_res,
    output logic [stfp_pkg::TEXT_W-1:0]            o_velocity_text,
    output logic [stfp_pkg::TEXT_W-1:0]            o_rpm_text,
    output logic [stfp_pkg::TEXT_W-1:0]            o_gear_text,
    output logic signed [stfp_pkg::VAL_W-1:0]      o_velocity_value,
    output logic signed [stfp_pkg::SHOW_W-1:0]     o_velocity_shown
);
    import stfp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // controller: accept, convert ('V' only), then commit into the result
    // register once it is free; the held result keeps the slots stable
    stfp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: collect buffer, three text slots, atoi-style conversion
    // and the clamp for display
    stfp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_event_res      (o_event_res),
        .o_velocity_text  (o_velocity_text),
        .o_rpm_text       (o_rpm_text),
        .o_gear_text      (o_gear_text),
        .o_velocity_value (o_velocity_value),
        .o_velocity_shown (o_velocity_shown)
    );

endmodule

// ----- tb/tb_serial_tagged_field_parser.sv -----
// tb_serial_tagged_field_parser: self-checking bench for the serial tagged field parser
// depends on stfp_pkg and serial_tagged_field_parser; a scoreboard class predicts every result
module tb_serial_tagged_field_parser;
    import stfp_pkg::*;

    // one result as seen on the result channel
    typedef struct {
        logic [EV_W-1:0]          ev;
        logic [TEXT_W-1:0]        vel_txt;
        logic [TEXT_W-1:0]        rpm_txt;
        logic [TEXT_W-1:0]        gear_txt;
        logic signed [VAL_W-1:0]  vel_num;
        logic signed [SHOW_W-1:0] vel_shown;
    } t_field_report;

    // keeps its own copy of the parser state and a queue of reports still due
    class field_latch_scoreboard;
        logic [7:0]              held [BUF_BYTES];
        int unsigned             held_cnt;
        logic [TEXT_W-1:0]       vel_txt;
        logic [TEXT_W-1:0]       rpm_txt;
        logic [TEXT_W-1:0]       gear_txt;
        logic signed [VAL_W-1:0] vel_num;
        t_field_report           reports_due [$];
        int                      error_count;

        function new();
            clear_held();
            vel_txt     = '0;
            rpm_txt     = '0;
            gear_txt    = '0;
            vel_num     = '0;
            error_count = 0;
        endfunction

        function void clear_held();
            foreach (held[k]) held[k] = 8'h00;
            held_cnt = 0;
        endfunction

        // apply one accepted request byte and queue the report it causes
        function void note_byte(input logic [7:0] b);
            t_field_report     exp;
            logic [TEXT_W-1:0] text_word;
            int                pos;
            int                acc;
            bit                neg;
            text_word = '0;
            for (int i = 0; i < BUF_BYTES; i++) text_word[8*i +: 8] = held[i];
            if (b == CH_VEL) begin
                pos = 0;
                neg = 0;
                acc = 0;
                while (pos < BUF_BYTES && (held[pos] inside {CH_SPACE, [CH_TAB:CH_CR]})) pos++;
                if (pos < BUF_BYTES && (held[pos] inside {CH_PLUS, CH_MINUS})) begin
                    neg = (held[pos] == CH_MINUS);
                    pos++;
                end
                while (pos < BUF_BYTES && (held[pos] inside {[CH_ZERO:CH_NINE]})) begin
                    acc = acc * 10 + int'(held[pos] - CH_ZERO);
                    pos++;
                end
                vel_num = VAL_W'(neg ? -acc : acc);
                vel_txt = text_word;
                clear_held();
                exp.ev = EV_VEL;
            end else if (b == CH_RPM) begin
                rpm_txt = text_word;
                clear_held();
                exp.ev = EV_RPM;
            end else if (b == CH_GEAR) begin
                gear_txt = text_word;
                clear_held();
                exp.ev = EV_GEAR;
            end else if (held_cnt < BUF_BYTES) begin
                held[held_cnt] = b;
                held_cnt++;
                exp.ev = EV_STORED;
            end else begin
                clear_held();
                exp.ev = EV_OVERFLOW;
            end
            exp.vel_txt   = vel_txt;
            exp.rpm_txt   = rpm_txt;
            exp.gear_txt  = gear_txt;
            exp.vel_num   = vel_num;
            exp.vel_shown = SHOW_W'((vel_num > SHOW_LIMIT) ? SHOW_LIMIT : vel_num);
            reports_due.push_back(exp);
        endfunction

        // compare one accepted result against the oldest report due
        function void check_report(input t_field_report got);
            t_field_report exp;
            if (reports_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: result with no request waiting, event %0d", got.ev);
                return;
            end
            exp = reports_due.pop_front();
            if (got.ev !== exp.ev || got.vel_txt !== exp.vel_txt ||
                got.rpm_txt !== exp.rpm_txt || got.gear_txt !== exp.gear_txt ||
                got.vel_num !== exp.vel_num || got.vel_shown !== exp.vel_shown) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("ERROR: mismatch at %0t", $realtime);
                    $display("  exp ev=%0d vel=%h rpm=%h gear=%h num=%0d shown=%0d",
                             exp.ev, exp.vel_txt, exp.rpm_txt, exp.gear_txt,
                             exp.vel_num, exp.vel_shown);
                    $display("  got ev=%0d vel=%h rpm=%h gear=%h num=%0d shown=%0d",
                             got.ev, got.vel_txt, got.rpm_txt, got.gear_txt,
                             got.vel_num, got.vel_shown);
                end
            end
        endfunction
    endclass

    // run length and safety limits
    localparam int RANDOM_BYTES = 2000;
    localparam int STALL_LIMIT  = 5000;  // cycles with no handshake on either channel
    localparam int TAIL_CYCLES  = 40;    // well past the slowest 'V' conversion

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic i_valid   = 1'b0;
    logic i_ready   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;

    logic                     o_ready;
    logic                     o_valid;
    logic [EV_W-1:0]          o_event_res;
    logic [TEXT_W-1:0]        o_velocity_text;
    logic [TEXT_W-1:0]        o_rpm_text;
    logic [TEXT_W-1:0]        o_gear_text;
    logic signed [VAL_W-1:0]  o_velocity_value;
    logic signed [SHOW_W-1:0] o_velocity_shown;

    field_latch_scoreboard sb = new();

    int unsigned stall_cycles = 0;
    int unsigned bytes_sent   = 0;
    bit          calm_stretch = 1'b0;  // no idling on either side while set

    serial_tagged_field_parser i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_event_res      (o_event_res),
        .o_velocity_text  (o_velocity_text),
        .o_rpm_text       (o_rpm_text),
        .o_gear_text      (o_gear_text),
        .o_velocity_value (o_velocity_value),
        .o_velocity_shown (o_velocity_shown)
    );

    always #6 i_clk = ~i_clk;

    // result side: sample at the edge, then pick ready for the next cycle
    // stalls with a probability of 38 percent unless the calm stretch is on
    always @(posedge i_clk) begin
        t_field_report got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.ev        = o_event_res;
                got.vel_txt   = o_velocity_text;
                got.rpm_txt   = o_rpm_text;
                got.gear_txt  = o_gear_text;
                got.vel_num   = o_velocity_value;
                got.vel_shown = o_velocity_shown;
                sb.check_report(got);
            end
            i_ready <= calm_stretch || ($urandom_range(0, 99) >= 38);
        end
    end

    // cycles since the last handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog: nothing moved for far longer than any legal stall
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("serial_tagged_field_parser test failed");
        $finish;
    end

    // one request: optional idle cycles with valid low, then hold valid and
    // the byte steady until the parser takes it
    task automatic send_byte(input logic [7:0] b);
        while (!calm_stretch && $urandom_range(0, 99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // sender holds off until every result due has come back; always waits on
    // the clock before checking, so valid is never lowered and raised in one step
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.reports_due.size() != 0);
    endtask

    // a well formed field: blanks, optional sign, digits, maybe a stray byte,
    // never more than the buffer holds, then one of the three terminators
    task automatic send_field();
        int room;
        int n_blank;
        int n_digit;
        int pick;
        room    = BUF_BYTES;
        n_blank = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < n_blank; i++) begin
            pick = $urandom_range(0, 5);
            send_byte((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick));
        end
        room -= n_blank;
        if (room > 0 && $urandom_range(0, 2) == 0) begin
            send_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            room--;
        end
        n_digit = $urandom_range(0, room);
        for (int i = 0; i < n_digit; i++) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        room -= n_digit;
        if (room > 0 && $urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 3);
        send_byte((pick < 2) ? CH_VEL : (pick == 2) ? CH_RPM : CH_GEAR);
    endtask

    initial begin
        bit mid_drained;
        int burst;
        mid_drained = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        // velocity terminator on an empty buffer
        send_byte(CH_VEL);
        // nul stored as a plain byte, then rpm latch
        send_byte(8'h00);
        send_byte(CH_RPM);
        // largest positive value, clamped on the shown output
        send_text("9999999");
        send_byte(CH_VEL);
        // blank skip, sign, and a nul that ends the digits
        send_text("\t-1");
        send_byte(8'h00);
        send_byte(CH_VEL);
        // full buffer then one more plain byte: overflow clears it
        send_byte(8'hFF);
        send_text("+-abcd");
        send_byte(8'h80);
        // gear latch of the cleared, empty buffer
        send_byte(CH_GEAR);
        wait_drained();

        // random part: mostly well formed fields, the rest raw byte noise
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            calm_stretch = (bytes_sent >= 600 && bytes_sent < 1000);
            if (!mid_drained && bytes_sent >= 1300) begin
                wait_drained();
                mid_drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 75) begin
                send_field();
            end else begin
                // long bursts run into the full buffer case
                burst = $urandom_range(1, 10);
                for (int i = 0; i < burst; i++) send_byte(8'($urandom_range(0, 255)));
            end
        end
        calm_stretch = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.reports_due.size() == 0) begin
            $display("serial_tagged_field_parser test passed");
        end else begin
            $display("serial_tagged_field_parser test failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/stfp_pkg.sv
hdl/stfp_ctrl.sv
hdl/stfp_dp.sv
hdl/serial_tagged_field_parser.sv
tb/tb_serial_tagged_field_parser.sv
